// ===== src/fractal_perlin_height_defines.svh =====
// assertion macros shared by the fractal noise height block
// depends on nothing; expects clk and rst_n in the including module
`ifndef FRACTAL_PERLIN_HEIGHT_DEFINES_SVH
`define FRACTAL_PERLIN_HEIGHT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPH_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("fph assertion failed");
`define FPH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fph implication failed");
`else
`define FPH_ASSERT(label, expr)
`define FPH_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ===== src/fph_pkg.sv =====
// constants and types of the fractal noise height block
// used by every module of the block
`default_nettype none
package fph_pkg;
  localparam int TBL_AW   = 10;
  localparam int TBL_SIZE = 1024;
  localparam int OCT_N    = 4;
  localparam int BASE_SH  = 3;
  localparam int POS_W    = 18;
  localparam int GRAD_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int SPOS_W   = POS_W + BASE_SH + OCT_N - 1;
  localparam int INT_W    = SPOS_W - FRAC_W;
  localparam int V_W      = 32;
  localparam int ACC_W    = V_W + OCT_N;
  localparam int LAT      = 10;
  localparam int ROW_MUL  = 41;
  localparam int COL_MUL  = 43;
  localparam int H_MAX    = 131071;
  localparam int H_MIN    = -131072;

  typedef enum logic {
    ACT_EVAL = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;
endpackage
`default_nettype wire

// ===== src/fractal_perlin_height.sv =====
// Four-octave gradient noise height. One word per clock is accepted while in_stall is
// low, loads and evaluations alike, and each gives one result word; the result passes
// through the octave pipeline (table read, dot products, ease, two blends).
// Every octave keeps four copies of the 1024-entry gradient table so that all
// sixteen corners are read in the same clock; a load writes all copies in order
// with later reads, and an out_stall while out_valid is high holds the whole pipeline.
`default_nettype none
`include "fractal_perlin_height_defines.svh"
module fractal_perlin_height import fph_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic [TBL_AW-1:0]       in_entry_index,
  input  logic signed [GRAD_W-1:0] in_grad_x,
  input  logic signed [GRAD_W-1:0] in_grad_y,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_height,
  output logic                    out_was_load
);
  logic en;
  logic vld_r [LAT];
  logic load_r [LAT];
  logic out_valid_r;
  logic s0_action_r;
  logic [TBL_AW-1:0] s0_idx_r;
  logic [2*GRAD_W-1:0] s0_grad_r;
  logic signed [POS_W-1:0] s0_x_r, s0_y_r;
  logic signed [POS_W-1:0] height_r;
  logic was_load_r;
  logic wr_en;
  logic signed [SPOS_W-1:0] spx [OCT_N];
  logic signed [SPOS_W-1:0] spy [OCT_N];
  logic signed [V_W-1:0] v [OCT_N];
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] hsum;
  logic signed [POS_W-1:0] height_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign en = !in_stall;
  assign wr_en = en && vld_r[0] && (s0_action_r == ACT_LOAD) &&
                 ({1'b0, s0_idx_r} < (TBL_AW+1)'(TBL_SIZE));

  always_comb begin
    for (int k = 0; k < OCT_N; k++) begin
      spx[k] = SPOS_W'(s0_x_r) <<< (BASE_SH + k);
      spy[k] = SPOS_W'(s0_y_r) <<< (BASE_SH + k);
    end
  end

  for (genvar k = 0; k < OCT_N; k++) begin : g_oct
    fph_octave u_oct (
      .clk     (clk),
      .en      (en),
      .wr_en   (wr_en),
      .wr_addr (s0_idx_r),
      .wr_data (s0_grad_r),
      .px      (spx[k]),
      .py      (spy[k]),
      .v       (v[k])
    );
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < OCT_N; k++) begin
      acc = acc + (ACC_W'(v[k]) <<< (OCT_N - 1 - k));
    end
    hsum = (acc + (ACC_W'(1) <<< (BASE_SH + OCT_N - 2))) >>> (BASE_SH + OCT_N - 1);
    priority if (hsum > ACC_W'(H_MAX)) begin
      height_nxt = POS_W'(H_MAX);
    end else if (hsum < ACC_W'(H_MIN)) begin
      height_nxt = POS_W'(H_MIN);
    end else begin
      height_nxt = POS_W'(hsum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_action_r <= in_action;
      s0_idx_r    <= in_entry_index;
      s0_grad_r   <= {in_grad_y, in_grad_x};
      s0_x_r      <= in_pos_x;
      s0_y_r      <= in_pos_y;
      load_r[0]   <= (in_action == ACT_LOAD);
      for (int i = 1; i < LAT; i++) begin
        load_r[i] <= load_r[i-1];
      end
      was_load_r  <= load_r[LAT-1];
      height_r    <= load_r[LAT-1] ? '0 : height_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_height   = height_r;
  assign out_was_load = was_load_r;

  `FPH_ASSERT(a_stall_from_out, in_stall == (out_valid_r && out_stall))
  `FPH_ASSERT_IMP(a_load_zero, out_valid_r && was_load_r, height_r == '0)
  `FPH_ASSERT_IMP(a_write_moves, wr_en, en && vld_r[0])
endmodule
`default_nettype wire

// ===== src/fph_ram.sv =====
// one gradient table copy: one write port, one registered read port
// depends on fph_pkg
`default_nettype none
module fph_ram import fph_pkg::*; (
  input  logic                  clk,
  input  logic                  we,
  input  logic [TBL_AW-1:0]     waddr,
  input  logic [2*GRAD_W-1:0]   wdata,
  input  logic                  re,
  input  logic [TBL_AW-1:0]     raddr,
  output logic [2*GRAD_W-1:0]   rdata
);
  logic [2*GRAD_W-1:0] mem [TBL_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/fph_octave.sv =====
// one noise octave: lattice hash, four table copies, dot, ease and blend pipeline
// depends on fph_pkg and fph_ram
`default_nettype none
module fph_octave import fph_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     wr_en,
  input  logic [TBL_AW-1:0]        wr_addr,
  input  logic [2*GRAD_W-1:0]      wr_data,
  input  logic signed [SPOS_W-1:0] px,
  input  logic signed [SPOS_W-1:0] py,
  output logic signed [V_W-1:0]    v
);
  localparam logic signed [17:0] ONE = 18'sd65536;

  logic signed [INT_W-1:0] ix, iy;
  logic signed [16:0] ax, ay;
  logic [TBL_AW-1:0] h0;
  logic [TBL_AW-1:0] addr [4];
  logic [2*GRAD_W-1:0] rd [4];

  always_comb begin
    ix = signed'(px[SPOS_W-1:FRAC_W]);
    iy = signed'(py[SPOS_W-1:FRAC_W]);
    ax = signed'({1'b0, px[FRAC_W-1:0]});
    ay = signed'({1'b0, py[FRAC_W-1:0]});
    if (px[SPOS_W-1] && (px[FRAC_W-1:0] != '0)) begin
      ix = ix + INT_W'(1);
      ax = signed'({1'b1, px[FRAC_W-1:0]});
    end
    if (py[SPOS_W-1] && (py[FRAC_W-1:0] != '0)) begin
      iy = iy + INT_W'(1);
      ay = signed'({1'b1, py[FRAC_W-1:0]});
    end
    h0 = TBL_AW'(TBL_AW'(ix) * TBL_AW'(ROW_MUL)) + TBL_AW'(TBL_AW'(iy) * TBL_AW'(COL_MUL));
    addr[0] = h0;
    addr[1] = h0 + TBL_AW'(ROW_MUL);
    addr[2] = h0 + TBL_AW'(COL_MUL);
    addr[3] = h0 + TBL_AW'(ROW_MUL + COL_MUL);
  end

  for (genvar c = 0; c < 4; c++) begin : g_ram
    fph_ram u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (en),
      .raddr (addr[c]),
      .rdata (rd[c])
    );
  end

  // stage registers
  logic signed [16:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  logic signed [33:0] ppx_r [4];
  logic signed [33:0] ppy_r [4];
  logic signed [33:0] aax_r, aay_r;
  logic signed [19:0] d3_r [4];
  logic signed [19:0] d4_r [4];
  logic signed [19:0] d5_r [4];
  logic signed [17:0] a2x_r, a2y_r;
  logic signed [34:0] a2ax_r, a2ay_r;
  logic signed [17:0] a2x4_r, a2y4_r;
  logic signed [20:0] ex_r, ey_r, ey6_r, ey7_r;
  logic signed [41:0] m1_r, m2_r;
  logic signed [19:0] d0_6_r, d2_6_r;
  logic signed [27:0] i1_r, i2_r;
  logic signed [49:0] m3_r;
  logic signed [27:0] i1_8_r;
  logic signed [V_W-1:0] v_r;

  logic signed [17:0] ox [4];
  logic signed [17:0] oy [4];
  logic signed [34:0] dsum [4];
  logic signed [33:0] rx, ry;
  logic signed [34:0] r3x, r3y;
  logic signed [18:0] a3x, a3y;
  logic signed [41:0] rm1, rm2;
  logic signed [49:0] rm3;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ox[c] = c[0] ? (18'(ax1_r) - ONE) : 18'(ax1_r);
      oy[c] = c[1] ? (18'(ay1_r) - ONE) : 18'(ay1_r);
      dsum[c] = 35'(ppx_r[c]) + 35'(ppy_r[c]) + 35'sd16384;
    end
    rx  = aax_r + 34'sd32768;
    ry  = aay_r + 34'sd32768;
    r3x = a2ax_r + 35'sd32768;
    r3y = a2ay_r + 35'sd32768;
    a3x = signed'(r3x[34:16]);
    a3y = signed'(r3y[34:16]);
    rm1 = m1_r + 42'sd32768;
    rm2 = m2_r + 42'sd32768;
    rm3 = m3_r + 50'sd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= ax;
      ay1_r <= ay;
      for (int c = 0; c < 4; c++) begin
        ppx_r[c] <= 34'(ox[c]) * 34'(signed'(rd[c][GRAD_W-1:0]));
        ppy_r[c] <= 34'(oy[c]) * 34'(signed'(rd[c][2*GRAD_W-1:GRAD_W]));
        d3_r[c]  <= signed'(dsum[c][34:15]);
        d4_r[c]  <= d3_r[c];
        d5_r[c]  <= d4_r[c];
      end
      aax_r  <= 34'(ax1_r) * 34'(ax1_r);
      aay_r  <= 34'(ay1_r) * 34'(ay1_r);
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      a2x_r  <= signed'(rx[33:16]);
      a2y_r  <= signed'(ry[33:16]);
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      a2ax_r <= 35'(a2x_r) * 35'(ax3_r);
      a2ay_r <= 35'(a2y_r) * 35'(ay3_r);
      a2x4_r <= a2x_r;
      a2y4_r <= a2y_r;
      ex_r   <= 21'(a2x4_r) * 21'sd3 - 21'(a3x) * 21'sd2;
      ey_r   <= 21'(a2y4_r) * 21'sd3 - 21'(a3y) * 21'sd2;
      m1_r   <= 42'(ex_r) * 42'(21'(d5_r[1]) - 21'(d5_r[0]));
      m2_r   <= 42'(ex_r) * 42'(21'(d5_r[3]) - 21'(d5_r[2]));
      d0_6_r <= d5_r[0];
      d2_6_r <= d5_r[2];
      ey6_r  <= ey_r;
      i1_r   <= 28'(d0_6_r) + 28'(signed'(rm1[41:16]));
      i2_r   <= 28'(d2_6_r) + 28'(signed'(rm2[41:16]));
      ey7_r  <= ey6_r;
      m3_r   <= 50'(ey7_r) * 50'(29'(i2_r) - 29'(i1_r));
      i1_8_r <= i1_r;
      v_r    <= V_W'(i1_8_r) + V_W'(signed'(rm3[49:16]));
    end
  end

  assign v = v_r;
endmodule
`default_nettype wire

// ===== test/tb_fractal_perlin_height.sv =====
// testbench for fractal_perlin_height: fills the gradient table, then checks
// directed and random height evaluations against an in-bench fixed-point predictor
// depends on fph_pkg and the fractal_perlin_height rtl
`default_nettype none
module tb_fractal_perlin_height;
  import fph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [POS_W-1:0] height;
    logic                    was_load;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_action = ACT_EVAL;
  logic [TBL_AW-1:0]        in_entry_index = '0;
  logic signed [GRAD_W-1:0] in_grad_x = '0;
  logic signed [GRAD_W-1:0] in_grad_y = '0;
  logic signed [POS_W-1:0]  in_pos_x = '0;
  logic signed [POS_W-1:0]  in_pos_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POS_W-1:0]  out_height;
  logic                     out_was_load;

  logic [31:0] grad_tbl [TBL_SIZE];
  result_t     pending_heights [$];
  int          mismatches = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  localparam int WATCHDOG = 5000;

  fractal_perlin_height i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_entry_index, .in_grad_x,
    .in_grad_y, .in_pos_x, .in_pos_y, .out_valid, .out_stall, .out_height, .out_was_load
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint ease(longint a);
    longint a2, a3;
    a2 = rnd_shr(a * a, FRAC_W);
    a3 = rnd_shr(a2 * a, FRAC_W);
    return 3 * a2 - 2 * a3;
  endfunction

  function automatic longint blend(longint lo, longint hi, longint e);
    return lo + rnd_shr(e * (hi - lo), FRAC_W);
  endfunction

  function automatic longint corner(longint row, longint col, longint ox, longint oy);
    longint      h;
    logic [31:0] g;
    h = row * ROW_MUL + col * COL_MUL;
    g = grad_tbl[h[TBL_AW-1:0]];
    return rnd_shr(ox * longint'($signed(g[15:0])) + oy * longint'($signed(g[31:16])), 15);
  endfunction

  function automatic longint gradient_noise(longint px, longint py);
    longint one, ix, iy, ax, ay, ex;
    one = longint'(1) <<< FRAC_W;
    ix = px / one;
    iy = py / one;
    ax = px - ix * one;
    ay = py - iy * one;
    ex = ease(ax);
    return blend(blend(corner(ix, iy, ax, ay), corner(ix + 1, iy, ax - one, ay), ex),
                 blend(corner(ix, iy + 1, ax, ay - one),
                       corner(ix + 1, iy + 1, ax - one, ay - one), ex),
                 ease(ay));
  endfunction

  function automatic logic signed [POS_W-1:0] predict_height(longint x, longint y);
    longint acc, f, h;
    acc = 0;
    for (int k = 0; k < OCT_N; k++) begin
      f = longint'(1) <<< (BASE_SH + k);
      acc += gradient_noise(x * f, y * f) <<< (OCT_N - 1 - k);
    end
    h = rnd_shr(acc, BASE_SH + OCT_N - 1);
    if (h > H_MAX) h = H_MAX;
    if (h < H_MIN) h = H_MIN;
    return h[POS_W-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic send_word(action_t act, logic [TBL_AW-1:0] idx, logic [GRAD_W-1:0] gx,
                           logic [GRAD_W-1:0] gy, logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    result_t r;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_entry_index <= idx;
    in_grad_x <= gx;
    in_grad_y <= gy;
    in_pos_x <= px;
    in_pos_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
    if (act == ACT_LOAD) begin
      grad_tbl[idx] = {gy, gx};
      r.height = '0;
      r.was_load = 1'b1;
    end else begin
      r.height = predict_height(longint'($signed(px)), longint'($signed(py)));
      r.was_load = 1'b0;
    end
    pending_heights.insert(pending_heights.size(), r);
  endtask

  task automatic load_random(int idx);
    send_word(ACT_LOAD, TBL_AW'(idx), GRAD_W'($urandom), GRAD_W'($urandom),
              POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic eval_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    send_word(ACT_EVAL, TBL_AW'($urandom), GRAD_W'($urandom), GRAD_W'($urandom), px, py);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heights.size() != 0) @(posedge clk);
  endtask

  task automatic test_table_fill();
    send_word(ACT_LOAD, TBL_AW'(0), 16'h8000, 16'h8000, '0, '0);
    send_word(ACT_LOAD, TBL_AW'(1), 16'h7fff, 16'h7fff, '1, '1);
    send_word(ACT_LOAD, TBL_AW'(2), 16'h7fff, 16'h8000, '0, '0);
    for (int i = 3; i < TBL_SIZE; i++) load_random(i);
  endtask

  task automatic test_extreme_positions();
    logic [POS_W-1:0] corners [8];
    corners = '{18'h00000, 18'h1ffff, 18'h20000, 18'h3ffff,
                18'h00001, 18'h10000, 18'h30000, 18'h08000};
    for (int i = 0; i < 8; i++) eval_at(corners[i], corners[(i * 3 + 1) % 8]);
    send_word(ACT_LOAD, TBL_AW'(1023), 16'h8000, 16'h7fff, '0, '0);
    eval_at(18'h1ffff, 18'h1ffff);
    eval_at(18'h20000, 18'h20000);
    eval_at(18'h3fff0, 18'h00010);
    drain();
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 1000; n++) begin
      quiet = (n >= 400 && n < 600);
      if (n == 700) drain();
      if ($urandom_range(99) < 12) load_random(int'($urandom_range(TBL_SIZE - 1)));
      else eval_at(POS_W'($urandom), POS_W'($urandom));
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && $urandom_range(99) < 7;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (pending_heights.size() == 0) begin
        report_mismatch("unexpected word", out_height, 0);
      end else begin
        want = pending_heights.pop_front();
        if (out_height !== want.height) report_mismatch("height", out_height, want.height);
        if (out_was_load !== want.was_load)
          report_mismatch("was_load", out_was_load, want.was_load);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_fractal_perlin_height NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_extreme_positions();
    test_random_mix();
    drain();
    repeat (LAT + 5) @(posedge clk);
    $display("covered %0d words in, %0d words out: full table load, extreme and random",
             words_in, words_out);
    $display("positions, table reloads mixed with evaluations, with stalls on both sides");
    if (mismatches == 0 && pending_heights.size() == 0) begin
      $display("tb_fractal_perlin_height OK");
    end else begin
      $display("tb_fractal_perlin_height NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
